### src/gdr_pkg.sv
// Shared types and constants for the grid DDA ray caster.
// No dependencies; imported by gdr_div and grid_dda_ray_caster_top.
`timescale 1ns / 1ps

package gdr_pkg;

   localparam int FRAC_BITS = 12;
   localparam int PT_W      = 18;
   localparam int DIST_W    = 17;
   localparam int MAG_W     = 18;
   localparam int LEN_W     = 19;
   localparam int UNIT_W    = 24;
   localparam int RL_W      = 25;
   localparam int SQ_W      = 37;
   localparam int NUM_W     = 43;

   localparam logic [0:0]        CMD_LOAD     = 1'b0;
   localparam logic [0:0]        CMD_CAST     = 1'b1;
   localparam logic [DIST_W-1:0] MAX_DIST_RST = 17'd65536;
   localparam logic [UNIT_W-1:0] UNIT_MAX     = 24'hFFFFFF;
   localparam logic [DIST_W-1:0] DIST_MAX     = 17'h1FFFF;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_USX,
      ST_USXS,
      ST_USXW,
      ST_USY,
      ST_USYS,
      ST_USYW,
      ST_RLX,
      ST_RLY,
      ST_STEP,
      ST_CHECK,
      ST_PMX,
      ST_PDXS,
      ST_PDXW,
      ST_PMY,
      ST_PDYS,
      ST_PDYW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

### src/gdr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gdr_pkg for operand widths and control structs.
`timescale 1ns / 1ps

module gdr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  gdr_pkg::div_ctl_type        ctl,
   input  logic [gdr_pkg::NUM_W-1:0]   dividend,
   input  logic [gdr_pkg::LEN_W-1:0]   divisor,
   output gdr_pkg::div_sts_type        sts,
   output logic [gdr_pkg::NUM_W-1:0]   quotient
);
   import gdr_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff;
   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [LEN_W:0]   trial;
   logic             fits;
   logic [LEN_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         cnt_ff <= CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

### src/grid_dda_ray_caster_top.sv
// Top level of the grid DDA ray caster: wall map memory, sequencer, datapath.
// Depends on gdr_pkg and gdr_div.
`timescale 1ns / 1ps

// Usage:
//   req channel: tuser[0] is the command (0 load a map cell, 1 cast a ray).
//   A load writes one wall bit and returns nothing.
//   A cast returns one transfer on rsp: tuser[0] hit, tdata the point and
//   distance. csr_we/csr_wdata set the ray length limit (Q5.12); the user
//   writes them only when idle, as the block itself does not enforce it.
//   A cast runs through squaring, a square root, up to two unit-step
//   divisions (setup, start, 43 quotient bits, done), the first-boundary
//   setup, the grid steps (map read plus wall test on the registered-read
//   memory) plus one closing step, and on a hit two divisions for the
//   intersection point.
//   The shared divider and the map read port set the cast timing.
//   One cast is in flight at a time; req_tready is high only when the
//   sequencer is idle. After reset the wall map is cleared one cell a cycle,
//   all MAP_W*MAP_H cells, with req_tready low. The result sits in an output
//   register; a new item is taken while it waits, and the sequencer holds
//   at the end of the next cast until rsp_tready frees that register.
module grid_dda_ray_caster_top #(
   parameter int MAP_W = 16,
   parameter int MAP_H = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_x, cell_y, cell_wall, start_x, start_y, target_x, target_y, zero fill
   input  logic [79:0] req_tdata,
   // command
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // point_x, point_y, distance, zero fill
   output logic [55:0] rsp_tdata,
   // hit
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   import gdr_pkg::*;

   localparam int DEPTH = MAP_W * MAP_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int MAXD  = (MAP_W > MAP_H) ? MAP_W : MAP_H;
   localparam int CW    = $clog2(((MAXD > 16) ? MAXD : 16) + 1) + 1;
   localparam int XW    = CW + AW;

   state_type state_ff, state_in;

   logic             map_mem [DEPTH];
   logic             rd_bit_ff;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic             wr_bit;
   logic [AW-1:0]    clr_ff;

   logic [DIST_W-1:0] maxd_ff;

   logic [15:0]       sx_ff, sy_ff;
   logic [PT_W-1:0]   tx_ff, ty_ff;
   logic              xneg_ff, yneg_ff;
   logic [MAG_W-1:0]  adx_ff, ady_ff;
   logic [SQ_W-1:0]   v_ff, r_ff, bit_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [UNIT_W-1:0] usx_ff, usy_ff;
   logic [RL_W-1:0]   rlx_ff, rly_ff, dist_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic              found_ff;
   logic [PT_W-1:0]   px_ff, py_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [LEN_W-1:0]  den_ff;

   logic              rsp_valid_ff;
   logic [55:0]       rsp_data_ff;
   logic              rsp_hit_ff;

   div_ctl_type       div_ctl;
   div_sts_type       div_sts;
   logic [NUM_W-1:0]  div_q;

   logic              req_xfer;
   logic              is_cast;
   logic              rsp_free;
   logic [3:0]        ld_x, ld_y;
   logic signed [18:0] dx_w, dy_w;
   logic [SQ_W-1:0]   root_sum;
   logic              take_x;
   logic signed [CW-1:0] nx, ny;
   logic              outside;
   logic [XW-1:0]     addr_wide;
   logic [XW-1:0]     ld_wide;
   logic [12:0]       fx, fy;
   logic [NUM_W-1:0]  us_sat_src;
   logic [UNIT_W-1:0] us_sat;
   logic              pneg;
   logic [15:0]       pstart;
   logic signed [NUM_W+1:0] psum;
   logic [PT_W-1:0]   psat;

   gdr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (num_ff),
      .divisor  (den_ff),
      .sts      (div_sts),
      .quotient (div_q)
   );

   // input decode and shared combinational helpers
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      req_xfer   = req_tvalid && req_tready;
      is_cast    = (req_tuser[0] == CMD_CAST);
      rsp_free   = !rsp_valid_ff || rsp_tready;
      ld_x       = req_tdata[3:0];
      ld_y       = req_tdata[7:4];
      dx_w       = $signed({req_tdata[58], req_tdata[58:41]})
                   - $signed({3'b000, req_tdata[24:9]});
      dy_w       = $signed({req_tdata[76], req_tdata[76:59]})
                   - $signed({3'b000, req_tdata[40:25]});
      root_sum   = v_ff + SQ_W'(ady_ff * ady_ff);

      take_x  = rlx_ff < rly_ff;
      nx      = cx_ff;
      ny      = cy_ff;
      if (take_x) begin
         nx = xneg_ff ? cx_ff - CW'(1) : cx_ff + CW'(1);
      end else begin
         ny = yneg_ff ? cy_ff - CW'(1) : cy_ff + CW'(1);
      end
      outside = (nx < 0) || (nx >= CW'(MAP_W)) || (ny < 0) || (ny >= CW'(MAP_H));
      addr_wide = XW'(unsigned'(ny)) * XW'(MAP_W) + XW'(unsigned'(nx));
      rd_addr   = addr_wide[AW-1:0];
      ld_wide   = XW'(ld_y) * XW'(MAP_W) + XW'(ld_x);

      fx = xneg_ff ? {1'b0, sx_ff[11:0]} : 13'd4096 - {1'b0, sx_ff[11:0]};
      fy = yneg_ff ? {1'b0, sy_ff[11:0]} : 13'd4096 - {1'b0, sy_ff[11:0]};

      us_sat_src = div_q;
      us_sat     = (us_sat_src > NUM_W'(UNIT_MAX)) ? UNIT_MAX : us_sat_src[UNIT_W-1:0];

      pneg   = (state_ff == ST_PDXW) ? xneg_ff : yneg_ff;
      pstart = (state_ff == ST_PDXW) ? sx_ff : sy_ff;
      psum   = $signed({{(NUM_W-14){1'b0}}, pstart})
               + (pneg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q}));
      if (psum > (NUM_W+2)'(131071)) begin
         psat = 18'h1FFFF;
      end else if (psum < -(NUM_W+2)'(131072)) begin
         psat = 18'h20000;
      end else begin
         psat = psum[PT_W-1:0];
      end

      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_bit  = 1'b0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (req_xfer && !is_cast && (ld_x < MAP_W) && (ld_y < MAP_H)) begin
         wr_en   = 1'b1;
         wr_addr = ld_wide[AW-1:0];
         wr_bit  = req_tdata[8];
      end
   end

   // wall map, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= map_mem[rd_addr];
   end

   // next state and divider control
   always_comb begin
      state_in      = state_ff;
      div_ctl.start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_xfer && is_cast) state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_ROOT;
         ST_ROOT:  if (bit_ff == '0) state_in = ST_USX;
         ST_USX:   state_in = (adx_ff == '0) ? ST_USY : ST_USXS;
         ST_USXS: begin
            div_ctl.start = 1'b1;
            state_in      = ST_USXW;
         end
         ST_USXW:  if (div_sts.done) state_in = ST_USY;
         ST_USY:   state_in = (ady_ff == '0) ? ST_RLX : ST_USYS;
         ST_USYS: begin
            div_ctl.start = 1'b1;
            state_in      = ST_USYW;
         end
         ST_USYW:  if (div_sts.done) state_in = ST_RLX;
         ST_RLX:   state_in = ST_RLY;
         ST_RLY:   state_in = ST_STEP;
         ST_STEP: begin
            if (dist_ff >= RL_W'(maxd_ff)) begin
               state_in = ST_DONE;
            end else if (outside) begin
               state_in = (len_ff == '0) ? ST_DONE : ST_PMX;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rd_bit_ff) begin
               state_in = (len_ff == '0) ? ST_DONE : ST_PMX;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_PMX:   state_in = ST_PDXS;
         ST_PDXS: begin
            div_ctl.start = 1'b1;
            state_in      = ST_PDXW;
         end
         ST_PDXW:  if (div_sts.done) state_in = ST_PMY;
         ST_PMY:   state_in = ST_PDYS;
         ST_PDYS: begin
            div_ctl.start = 1'b1;
            state_in      = ST_PDYW;
         end
         ST_PDYW:  if (div_sts.done) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         maxd_ff  <= MAX_DIST_RST;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_we) begin
            maxd_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // cast datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            sx_ff    <= req_tdata[24:9];
            sy_ff    <= req_tdata[40:25];
            tx_ff    <= req_tdata[58:41];
            ty_ff    <= req_tdata[76:59];
            xneg_ff  <= dx_w < 0;
            yneg_ff  <= dy_w < 0;
            adx_ff   <= (dx_w < 0) ? MAG_W'(-dx_w) : MAG_W'(dx_w);
            ady_ff   <= (dy_w < 0) ? MAG_W'(-dy_w) : MAG_W'(dy_w);
            cx_ff    <= CW'(req_tdata[24:21]);
            cy_ff    <= CW'(req_tdata[40:37]);
            dist_ff  <= '0;
            found_ff <= 1'b0;
         end
         ST_SQX: v_ff <= SQ_W'(adx_ff * adx_ff);
         ST_SQY: begin
            v_ff   <= root_sum;
            r_ff   <= '0;
            bit_ff <= SQ_W'(1) << 36;
         end
         ST_ROOT: begin
            if (bit_ff != '0) begin
               if (v_ff >= r_ff + bit_ff) begin
                  v_ff <= v_ff - (r_ff + bit_ff);
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end else begin
               len_ff <= r_ff[LEN_W-1:0];
            end
         end
         ST_USX: begin
            usx_ff <= UNIT_MAX;
            num_ff <= NUM_W'({len_ff, 12'b0});
            den_ff <= LEN_W'(adx_ff);
         end
         ST_USXW: if (div_sts.done) usx_ff <= us_sat;
         ST_USY: begin
            usy_ff <= UNIT_MAX;
            num_ff <= NUM_W'({len_ff, 12'b0});
            den_ff <= LEN_W'(ady_ff);
         end
         ST_USYW: if (div_sts.done) usy_ff <= us_sat;
         ST_RLX: rlx_ff <= RL_W'((37'(fx) * 37'(usx_ff)) >> FRAC_BITS);
         ST_RLY: rly_ff <= RL_W'((37'(fy) * 37'(usy_ff)) >> FRAC_BITS);
         ST_STEP: begin
            if (dist_ff < RL_W'(maxd_ff)) begin
               cx_ff <= nx;
               cy_ff <= ny;
               if (take_x) begin
                  dist_ff <= rlx_ff;
                  rlx_ff  <= rlx_ff + RL_W'(usx_ff);
               end else begin
                  dist_ff <= rly_ff;
                  rly_ff  <= rly_ff + RL_W'(usy_ff);
               end
               found_ff <= outside;
            end
            px_ff <= PT_W'(sx_ff);
            py_ff <= PT_W'(sy_ff);
         end
         ST_CHECK: found_ff <= rd_bit_ff;
         ST_PMX: begin
            num_ff <= NUM_W'(adx_ff * dist_ff);
            den_ff <= len_ff;
         end
         ST_PDXW: if (div_sts.done) px_ff <= psat;
         ST_PMY: num_ff <= NUM_W'(ady_ff * dist_ff);
         ST_PDYW: if (div_sts.done) py_ff <= psat;
         ST_DONE: begin
            if (rsp_free) begin
               rsp_hit_ff  <= found_ff;
               rsp_data_ff <= {3'b000,
                               (dist_ff > RL_W'(DIST_MAX)) ? DIST_MAX
                                                           : dist_ff[DIST_W-1:0],
                               found_ff ? py_ff : ty_ff,
                               found_ff ? px_ff : tx_ff};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

endmodule
